FILE: sv/prlt_pkg.sv
// ============================================================================
// prlt_pkg
// Shared types and codes for the priority range lookup table.
// ============================================================================
package prlt_pkg;

    // command codes
    localparam logic [1:0] CMD_ADD   = 2'd0;
    localparam logic [1:0] CMD_FIND  = 2'd1;
    localparam logic [1:0] CMD_CLEAR = 2'd2;

    // add status codes
    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_ZERO = 2'd1;
    localparam logic [1:0] ST_FULL = 2'd2;
    localparam logic [1:0] ST_WRAP = 2'd3;

    // one stored range
    typedef struct packed {
        logic [63:0] first;
        logic [63:0] last;
        logic [1:0]  kind;
        logic [31:0] handle;
    } t_entry;

    // control of the compare unit
    typedef struct packed {
        logic init;
        logic step;
    } t_scan_ctl;

    // running result of a find walk
    typedef struct packed {
        logic        found;
        logic [1:0]  kind;
        logic [31:0] handle;
        logic [63:0] vend;
    } t_scan_res;

endpackage

FILE: sv/prlt_store.sv
// ============================================================================
// prlt_store
// Range entry memory: one write port, one read port with registered data.
// ============================================================================
module prlt_store #(
    parameter int DEPTH = 16,
    parameter int IDX_W = 4
) (
    input  logic               i_clk,
    input  logic               i_wr_en,
    input  logic [IDX_W-1:0]   i_wr_addr,
    input  prlt_pkg::t_entry   i_wr_data,
    input  logic [IDX_W-1:0]   i_rd_addr,
    output prlt_pkg::t_entry   o_rd_data
);
    import prlt_pkg::*;

    t_entry r_mem [DEPTH];
    t_entry r_q;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        r_q <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_q;

endmodule

FILE: sv/prlt_scan.sv
// ============================================================================
// prlt_scan
// Shared compare unit: checks one entry per cycle against the query offset
// and keeps the running match and virtual end.
// ============================================================================
module prlt_scan (
    input  logic                i_clk,
    input  prlt_pkg::t_scan_ctl i_ctl,
    input  prlt_pkg::t_entry    i_entry,
    input  logic [63:0]         i_offset,
    output logic                o_hit,
    output prlt_pkg::t_scan_res o_res
);
    import prlt_pkg::*;

    t_scan_res r_res;
    logic      in_rng;
    logic      above;

    // range compare against the offset
    always_comb begin
        in_rng = (i_entry.first <= i_offset) && (i_entry.last >= i_offset);
        above  = (i_entry.first > i_offset) && (i_entry.first <= r_res.vend);
    end

    // running result
    always_ff @(posedge i_clk) begin
        if (i_ctl.init) begin
            r_res.found  <= 1'b0;
            r_res.kind   <= 2'd0;
            r_res.handle <= 32'd0;
            r_res.vend   <= '1;
        end else if (i_ctl.step) begin
            if (in_rng) begin
                r_res.found  <= 1'b1;
                r_res.kind   <= i_entry.kind;
                r_res.handle <= i_entry.handle;
                if (i_entry.last < r_res.vend) begin
                    r_res.vend <= i_entry.last;
                end
            end else if (above) begin
                r_res.vend <= i_entry.first - 64'd1;
            end
        end
    end

    assign o_hit = in_rng;
    assign o_res = r_res;

endmodule

FILE: sv/priority_range_lookup_table.sv
// ============================================================================
// priority_range_lookup_table
// Table of address ranges with add, find and clear commands. A find walks
// the stored ranges newest first through one compare unit and one memory
// read port, one range per cycle, stopping at the first range that holds the
// offset, and visits at most MAX_RANGES ranges. An add passes through a sum
// state and a write state; clear and unknown commands go straight to the
// result state. One transaction is worked on at a time; the next
// one is taken once the result has moved into the output register, which
// holds it until the consumer takes it, so the block is ready again in the
// cycle the result appears unless the previous result is still waiting. The
// range memory needs no clearing after reset: only entries below the stored
// count are ever read.
// ============================================================================
module priority_range_lookup_table #(
    parameter int MAX_RANGES = 16,
    localparam int CNT_W = $clog2(MAX_RANGES + 1),
    localparam int IDX_W = (MAX_RANGES > 1) ? $clog2(MAX_RANGES) : 1
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    // input channel
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  logic [1:0]        i_command,
    input  logic [63:0]       i_range_start,
    input  logic [63:0]       i_range_size,
    input  logic [1:0]        i_chunk_kind,
    input  logic [31:0]       i_payload_handle,
    input  logic [63:0]       i_query_offset,
    // output channel
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output logic [1:0]        o_status,
    output logic              o_found,
    output logic [1:0]        o_hit_kind,
    output logic [31:0]       o_hit_handle,
    output logic [63:0]       o_virtual_end,
    output logic [63:0]       o_dump_size,
    output logic [CNT_W-1:0]  o_entry_count
);
    import prlt_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_ADD   = 5'b00010,
        S_WRITE = 5'b00100,
        S_WALK  = 5'b01000,
        S_DONE  = 5'b10000
    } t_state;

    t_state             r_state, n_state;
    logic [CNT_W-1:0]   r_count;
    logic [63:0]        r_hi;
    logic [IDX_W-1:0]   r_idx, n_idx;
    logic [1:0]         r_cmd;
    logic [63:0]        r_start;
    logic [63:0]        r_size;
    logic [1:0]         r_kind;
    logic [31:0]        r_handle;
    logic [63:0]        r_offset;
    logic [64:0]        r_sum;
    logic [1:0]         r_st;
    logic               r_out_valid;
    logic [1:0]         r_o_status;
    logic               r_o_found;
    logic [1:0]         r_o_kind;
    logic [31:0]        r_o_handle;
    logic [63:0]        r_o_vend;
    logic [63:0]        r_o_dump;
    logic [CNT_W-1:0]   r_o_count;

    logic               in_acc;
    logic               out_free;
    logic               wr_en;
    t_entry             wr_data;
    t_entry             rd_data;
    t_scan_ctl          scan_ctl;
    t_scan_res          scan_res;
    logic               scan_hit;
    logic               wrap;
    logic [63:0]        top;

    assign in_acc   = i_in_valid && (r_state == S_IDLE);
    assign out_free = !r_out_valid || i_out_ready;

    // add arithmetic on the registered sum
    always_comb begin
        wrap           = r_sum[64] && (r_sum[63:0] != 64'd0);
        top            = r_sum[64] ? '1 : r_sum[63:0];
        wr_data.first  = r_start;
        wr_data.last   = r_sum[63:0] - 64'd1;
        wr_data.kind   = r_kind;
        wr_data.handle = r_handle;
        wr_en          = (r_state == S_WRITE) && (r_size != 64'd0) && !wrap
                         && (r_count < CNT_W'(MAX_RANGES));
    end

    // sequencer next state and walk index
    always_comb begin
        n_state       = r_state;
        n_idx         = r_idx;
        scan_ctl.init = 1'b0;
        scan_ctl.step = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    priority if (i_command == CMD_ADD) begin
                        n_state = S_ADD;
                    end else if (i_command == CMD_FIND) begin
                        scan_ctl.init = 1'b1;
                        if (r_count == '0) begin
                            n_state = S_DONE;
                        end else begin
                            n_idx   = IDX_W'(r_count - CNT_W'(1));
                            n_state = S_WALK;
                        end
                    end else begin
                        n_state = S_DONE;
                    end
                end
            end
            S_ADD: begin
                n_state = S_WRITE;
            end
            S_WRITE: begin
                n_state = S_DONE;
            end
            S_WALK: begin
                scan_ctl.step = 1'b1;
                if (scan_hit || (r_idx == '0)) begin
                    n_state = S_DONE;
                end else begin
                    n_idx = r_idx - IDX_W'(1);
                end
            end
            S_DONE: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_hi        <= 64'd0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (in_acc && (i_command == CMD_CLEAR)) begin
                r_count <= '0;
                r_hi    <= 64'd0;
            end else if (wr_en) begin
                r_count <= r_count + CNT_W'(1);
                if (top > r_hi) begin
                    r_hi <= top;
                end
            end
            if ((r_state == S_DONE) && out_free) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // transaction payload, sum and status
    always_ff @(posedge i_clk) begin
        r_idx <= n_idx;
        if (in_acc) begin
            r_cmd    <= i_command;
            r_start  <= i_range_start;
            r_size   <= i_range_size;
            r_kind   <= i_chunk_kind;
            r_handle <= i_payload_handle;
            r_offset <= i_query_offset;
            r_st     <= ST_OK;
        end
        if (r_state == S_ADD) begin
            r_sum <= {1'b0, r_start} + {1'b0, r_size};
        end
        if (r_state == S_WRITE) begin
            priority if (r_size == 64'd0) begin
                r_st <= ST_ZERO;
            end else if (wrap) begin
                r_st <= ST_WRAP;
            end else if (r_count >= CNT_W'(MAX_RANGES)) begin
                r_st <= ST_FULL;
            end else begin
                r_st <= ST_OK;
            end
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if ((r_state == S_DONE) && out_free) begin
            r_o_status <= r_st;
            r_o_dump   <= r_hi;
            r_o_count  <= r_count;
            if (r_cmd == CMD_FIND) begin
                r_o_found  <= scan_res.found;
                r_o_kind   <= scan_res.kind;
                r_o_handle <= scan_res.handle;
                r_o_vend   <= scan_res.vend;
            end else begin
                r_o_found  <= 1'b0;
                r_o_kind   <= 2'd0;
                r_o_handle <= 32'd0;
                r_o_vend   <= 64'd0;
            end
        end
    end

    prlt_store #(
        .DEPTH (MAX_RANGES),
        .IDX_W (IDX_W)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (r_count[IDX_W-1:0]),
        .i_wr_data (wr_data),
        .i_rd_addr (n_idx),
        .o_rd_data (rd_data)
    );

    prlt_scan u_scan (
        .i_clk    (i_clk),
        .i_ctl    (scan_ctl),
        .i_entry  (rd_data),
        .i_offset (r_offset),
        .o_hit    (scan_hit),
        .o_res    (scan_res)
    );

    assign o_in_ready    = (r_state == S_IDLE);
    assign o_out_valid   = r_out_valid;
    assign o_status      = r_o_status;
    assign o_found       = r_o_found;
    assign o_hit_kind    = r_o_kind;
    assign o_hit_handle  = r_o_handle;
    assign o_virtual_end = r_o_vend;
    assign o_dump_size   = r_o_dump;
    assign o_entry_count = r_o_count;

`ifndef NO_ASSERTIONS
    // stored count never exceeds the table depth
    a_count_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(MAX_RANGES))
        else $error("stored count above table depth");

    // the walk only visits stored entries
    a_walk_idx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WALK) |-> (CNT_W'(r_idx) < r_count))
        else $error("walk index outside stored entries");

    // an empty table has a zero dump size
    a_empty_dump: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == '0) |-> (r_hi == 64'd0))
        else $error("dump size nonzero with empty table");

    // a clear transaction empties the table
    a_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && (i_command == CMD_CLEAR)) |=> (r_count == '0))
        else $error("clear did not empty table");

    // no table write outside the add step
    a_write_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        wr_en |-> ((r_state == S_WRITE) && (r_cmd == CMD_ADD)))
        else $error("table write outside add");
`endif

endmodule

FILE: test/prlt_tb_pkg.sv
`timescale 1ns / 1ps
// ============================================================================
// prlt_tb_pkg
// Scoreboard for the priority range lookup table testbench. It keeps its own
// copy of the range table, works out the result of every accepted command
// and checks the results of the block against them in order.
// ============================================================================
package prlt_tb_pkg;

    import prlt_pkg::*;

    localparam int          RANGE_SLOTS = 16;
    localparam int          CNT_W       = $clog2(RANGE_SLOTS + 1);
    localparam logic [63:0] ALL_ONES    = 64'hFFFF_FFFF_FFFF_FFFF;
    // command value with no meaning, must leave the table alone
    localparam logic [1:0]  CMD_UNKNOWN = 2'd3;

    // one result transaction as seen on the output channel
    typedef struct packed {
        logic [1:0]       status;
        logic             found;
        logic [1:0]       kind;
        logic [31:0]      handle;
        logic [63:0]      vend;
        logic [63:0]      dump;
        logic [CNT_W-1:0] count;
    } t_outcome;

    class range_scoreboard;

        logic [63:0] range_first  [RANGE_SLOTS];
        logic [63:0] range_last   [RANGE_SLOTS];
        logic [1:0]  range_kind   [RANGE_SLOTS];
        logic [31:0] range_handle [RANGE_SLOTS];
        int          range_count;
        logic [63:0] top_end;
        t_outcome    expected_outcomes [$];
        int          fail_count;

        function new();
            range_count = 0;
            top_end     = '0;
            fail_count  = 0;
        endfunction

        // result of one command, updates the table copy
        function t_outcome lookup_outcome(input logic [1:0] cmd, input logic [63:0] start,
                                          input logic [63:0] size, input logic [1:0] kind,
                                          input logic [31:0] handle,
                                          input logic [63:0] offset);
            t_outcome    res;
            logic [63:0] last;
            logic [63:0] top;
            int          i;
            res = '0;
            case (cmd)
                CMD_ADD: begin
                    if (size == 64'd0) begin
                        res.status = ST_ZERO;
                    end else if (size - 64'd1 > ALL_ONES - start) begin
                        res.status = ST_WRAP;
                    end else if (range_count >= RANGE_SLOTS) begin
                        res.status = ST_FULL;
                    end else begin
                        last = start + (size - 64'd1);
                        range_first[range_count]  = start;
                        range_last[range_count]   = last;
                        range_kind[range_count]   = kind;
                        range_handle[range_count] = handle;
                        range_count++;
                        top = (last == ALL_ONES) ? ALL_ONES : last + 64'd1;
                        if (top > top_end) begin
                            top_end = top;
                        end
                        res.status = ST_OK;
                    end
                end
                CMD_FIND: begin
                    // newest first, newer ranges above the offset cut the end short
                    res.vend = ALL_ONES;
                    for (i = range_count - 1; i >= 0 && !res.found; i--) begin
                        if (range_first[i] <= offset && range_last[i] >= offset) begin
                            if (range_last[i] < res.vend) begin
                                res.vend = range_last[i];
                            end
                            res.found  = 1'b1;
                            res.kind   = range_kind[i];
                            res.handle = range_handle[i];
                        end else if (range_first[i] > offset &&
                                     range_first[i] - 64'd1 < res.vend) begin
                            res.vend = range_first[i] - 64'd1;
                        end
                    end
                end
                CMD_CLEAR: begin
                    range_count = 0;
                    top_end     = '0;
                end
                default: begin
                end
            endcase
            res.dump  = top_end;
            res.count = range_count[CNT_W-1:0];
            return res;
        endfunction

        task report(input string msg);
            $display("mismatch: %s", msg);
            fail_count++;
        endtask

        // accepted input transaction
        function void note_command(input logic [1:0] cmd, input logic [63:0] start,
                                   input logic [63:0] size, input logic [1:0] kind,
                                   input logic [31:0] handle, input logic [63:0] offset);
            expected_outcomes.push_back(lookup_outcome(cmd, start, size, kind, handle, offset));
        endfunction

        task compare_field(input string name, input logic [63:0] got,
                           input logic [63:0] want);
            if (got !== want) begin
                report($sformatf("%s got %h want %h", name, got, want));
            end
        endtask

        // accepted output transaction against the oldest expected one
        task check_outcome(input t_outcome got);
            t_outcome want;
            if (expected_outcomes.size() == 0) begin
                report("result with no command waiting");
            end else begin
                want = expected_outcomes.pop_front();
                compare_field("status", 64'(got.status), 64'(want.status));
                compare_field("found", 64'(got.found), 64'(want.found));
                compare_field("hit_kind", 64'(got.kind), 64'(want.kind));
                compare_field("hit_handle", 64'(got.handle), 64'(want.handle));
                compare_field("virtual_end", got.vend, want.vend);
                compare_field("dump_size", got.dump, want.dump);
                compare_field("entry_count", 64'(got.count), 64'(want.count));
            end
        endtask

        function int pending();
            return expected_outcomes.size();
        endfunction

    endclass

endpackage

FILE: test/testbench.sv
`timescale 1ns / 1ps
// ============================================================================
// testbench
// Drives add, find, clear and unknown commands into the priority range
// lookup table: a directed opening over the edge cases, then random traffic
// with ranges packed close together so finds hit, miss and get cut short.
// Both channels stall at random; every result is checked field by field.
// ============================================================================
module testbench;

    import prlt_pkg::*;
    import prlt_tb_pkg::*;

    localparam int RANDOM_ITEMS = 1800;
    localparam int STALL_LIMIT  = 2000;
    localparam int DRAIN_CYCLES = 2 * RANGE_SLOTS + 8;

    logic              i_clk            = 1'b0;
    logic              i_rst_n          = 1'b0;
    logic              i_in_valid       = 1'b0;
    logic              o_in_ready;
    logic [1:0]        i_command        = CMD_CLEAR;
    logic [63:0]       i_range_start    = '0;
    logic [63:0]       i_range_size     = '0;
    logic [1:0]        i_chunk_kind     = '0;
    logic [31:0]       i_payload_handle = '0;
    logic [63:0]       i_query_offset   = '0;
    logic              o_out_valid;
    logic              i_out_ready      = 1'b0;
    logic [1:0]        o_status;
    logic              o_found;
    logic [1:0]        o_hit_kind;
    logic [31:0]       o_hit_handle;
    logic [63:0]       o_virtual_end;
    logic [63:0]       o_dump_size;
    logic [CNT_W-1:0]  o_entry_count;

    t_outcome          seen;
    range_scoreboard   board;
    bit                calm         = 1'b0;
    int                idle_cycles  = 0;

    priority_range_lookup_table #(
        .MAX_RANGES (RANGE_SLOTS)
    ) i_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_ready       (o_in_ready),
        .i_command        (i_command),
        .i_range_start    (i_range_start),
        .i_range_size     (i_range_size),
        .i_chunk_kind     (i_chunk_kind),
        .i_payload_handle (i_payload_handle),
        .i_query_offset   (i_query_offset),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_status         (o_status),
        .o_found          (o_found),
        .o_hit_kind       (o_hit_kind),
        .o_hit_handle     (o_hit_handle),
        .o_virtual_end    (o_virtual_end),
        .o_dump_size      (o_dump_size),
        .o_entry_count    (o_entry_count)
    );

    assign seen = {o_status, o_found, o_hit_kind, o_hit_handle, o_virtual_end,
                   o_dump_size, o_entry_count};

    // clock
    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // address mostly near the bottom or the top, sometimes anywhere
    function automatic logic [63:0] rand_addr();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 55) begin
            return 64'($urandom_range(0, 2047));
        end else if (pick < 75) begin
            return ALL_ONES - 64'($urandom_range(0, 2047));
        end
        return {$urandom, $urandom};
    endfunction

    // one input transaction, with a random gap in front of it
    task automatic send_item(input logic [1:0] cmd, input logic [63:0] start,
                             input logic [63:0] size, input logic [1:0] kind,
                             input logic [31:0] handle, input logic [63:0] offset);
        while (!calm && $urandom_range(0, 99) < 14) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid       <= 1'b1;
        i_command        <= cmd;
        i_range_start    <= start;
        i_range_size     <= size;
        i_chunk_kind     <= kind;
        i_payload_handle <= handle;
        i_query_offset   <= offset;
        @(posedge i_clk);
        while (!o_in_ready) begin
            @(posedge i_clk);
        end
        board.note_command(cmd, start, size, kind, handle, offset);
    endtask

    // output side: check accepted results, stall at random
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            board.check_outcome(seen);
        end
        i_out_ready <= calm || ($urandom_range(0, 99) >= 14);
    end

    // watchdog on cycles with no transaction on either side
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= STALL_LIMIT) begin
            $display("status: fail");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin : stimulus
        logic [1:0]  cmd;
        logic [63:0] start;
        logic [63:0] size;
        logic [63:0] offset;
        logic [63:0] base;
        int          pick;
        int          slot;
        int          n;
        board = new();

        // reset
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: empty table, zero size, wrap, ranges at both ends
        send_item(CMD_CLEAR, '0, '0, 2'd0, '0, '0);
        send_item(CMD_FIND, '0, '0, 2'd0, '0, 64'd0);
        send_item(CMD_ADD, 64'd100, 64'd0, 2'd1, 32'h1111_1111, '0);
        send_item(CMD_ADD, ALL_ONES, 64'd2, 2'd2, 32'h2222_2222, '0);
        send_item(CMD_ADD, 64'd0, ALL_ONES, 2'd0, 32'h0000_0001, '0);
        send_item(CMD_ADD, ALL_ONES, 64'd1, 2'd2, 32'h8000_0000, '0);
        // overlapping ranges, the newer one must win and cut the end short
        send_item(CMD_ADD, 64'd1000, 64'd100, 2'd1, 32'hFFFF_FFFF, '0);
        send_item(CMD_ADD, 64'd1050, 64'd200, 2'd2, 32'h0000_0000, '0);
        send_item(CMD_FIND, '0, '0, 2'd0, '0, 64'd1060);
        send_item(CMD_FIND, '0, '0, 2'd0, '0, 64'd1020);
        send_item(CMD_FIND, '0, '0, 2'd0, '0, 64'd500);
        send_item(CMD_FIND, '0, '0, 2'd0, '0, ALL_ONES);
        send_item(CMD_UNKNOWN, ALL_ONES, ALL_ONES, 2'd2, 32'hFFFF_FFFF, ALL_ONES);
        // fill the table and go one past
        for (n = 0; n < 13; n++) begin
            send_item(CMD_ADD, 64'd2000 + 64'(n * 37), 64'($urandom_range(1, 64)),
                      2'(n % 3), $urandom, '0);
        end

        // random traffic, with a stretch where neither side stalls
        for (n = 0; n < RANDOM_ITEMS; n++) begin
            calm  = (n >= 700 && n < 1000);
            pick  = $urandom_range(0, 999);
            start = rand_addr();
            base  = 64'($urandom_range(0, 99));
            if (base < 6) begin
                size = 64'd0;
            end else if (base < 70) begin
                size = 64'($urandom_range(1, 300));
            end else if (base < 80) begin
                size = ALL_ONES - start + 64'd1;
            end else if (base < 88) begin
                size = {$urandom, $urandom};
            end else begin
                size = 64'($urandom_range(1, 4096));
            end
            // aim finds at range edges most of the time
            offset = rand_addr();
            if (board.range_count > 0 && $urandom_range(0, 99) < 60) begin
                slot = $urandom_range(0, board.range_count - 1);
                case ($urandom_range(0, 3))
                    0: offset = board.range_first[slot] - 64'd1;
                    1: offset = board.range_first[slot];
                    2: offset = board.range_last[slot];
                    default: offset = board.range_last[slot] + 64'd1;
                endcase
            end
            if (pick < 450) begin
                cmd = CMD_ADD;
            end else if (pick < 970) begin
                cmd = CMD_FIND;
            end else if (pick < 990) begin
                cmd = CMD_CLEAR;
            end else begin
                cmd = CMD_UNKNOWN;
            end
            send_item(cmd, start, size, 2'($urandom_range(0, 2)), $urandom, offset);
        end
        calm = 1'b0;
        i_in_valid <= 1'b0;

        // drain
        while (board.pending() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (board.pending() != 0) begin
            board.report("expected results left over");
        end
        if (board.fail_count == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
